/* rtl/irpd_pkg.sv */
// Shared constants, types and timing-window helpers for the pulse-distance IR decoder.
package irpd_pkg;

    // Frame layout: header, FRAME_BITS data pairs, end marker
    localparam int FRAME_BITS  = 32;
    localparam int FRAME_PAIRS = FRAME_BITS + 2;
    localparam int POS_W       = $clog2(FRAME_PAIRS + 1);
    localparam int CODE_W      = 32;

    // Input field widths
    localparam int TICKS_W = 15;
    localparam int CFG_W   = 10;
    localparam int TGT_W   = 13;

    // Width of ticks*10 and of the (target +/- margin) * k bounds
    localparam int BOUND_W = 23;

    // Nominal timings in microseconds
    localparam logic [TGT_W-1:0] HDR_MARK_US   = 13'd4500;
    localparam logic [TGT_W-1:0] HDR_SPACE_US  = 13'd4500;
    localparam logic [TGT_W-1:0] BIT_MARK_US   = 13'd560;
    localparam logic [TGT_W-1:0] ONE_SPACE_US  = 13'd1690;
    localparam logic [TGT_W-1:0] ZERO_SPACE_US = 13'd560;
    localparam logic [TGT_W-1:0] END_MARK_US   = 13'd560;
    localparam logic [TGT_W-1:0] END_SPACE_US  = 13'd0;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVEL = 2'd0,
        CFG_TICKS_PER_TEN_US = 2'd1,
        CFG_MARGIN_US = 2'd2
    } cfg_idx_t;

    // Frame status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_HEADER = 3'd2,
        ST_BIT    = 3'd3,
        ST_END    = 3'd4
    } status_t;

    // Acceptance window in scaled ticks: lo <= ticks*10 < hi
    typedef struct packed {
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
    } win_t;

    // Window for a target: lower bound clamped at zero when margin exceeds target
    function automatic win_t win_bounds(logic [TGT_W-1:0] target, logic [CFG_W-1:0] margin,
                                        logic [CFG_W-1:0] k);
        logic [TGT_W:0] lo_base;
        logic [TGT_W:0] hi_base;
        win_t           w;
        if (({1'b0, target} + (TGT_W+1)'(1)) > (TGT_W+1)'(margin)) begin
            lo_base = {1'b0, target} + (TGT_W+1)'(1) - (TGT_W+1)'(margin);
        end else begin
            lo_base = '0;
        end
        hi_base = {1'b0, target} + (TGT_W+1)'(margin);
        w.lo = BOUND_W'(lo_base) * BOUND_W'(k);
        w.hi = BOUND_W'(hi_base) * BOUND_W'(k);
        return w;
    endfunction

    // Duration check: ticks*10 by shift-and-add, then the two compares
    function automatic logic in_win(logic [TICKS_W-1:0] ticks, win_t w);
        logic [BOUND_W-1:0] scaled;
        scaled = (BOUND_W'(ticks) << 3) + (BOUND_W'(ticks) << 1);
        return (scaled >= w.lo) && (scaled < w.hi);
    endfunction

endpackage

/* rtl/ir_pulse_distance_decoder.sv */
// A word is first taken into the input register; a last word then loads its result
// into the result register, and m_tvalid shows that register's valid flag.
// Throughput: one pulse-pair word per cycle when not stalled; the input register and the result
// register are parted so a word is taken while a finished result waits.
// A stall holds only while the input register holds a last word and the result
// register holds a result that is not taken in that cycle.
// Reset (aresetn low, synchronous) empties both registers, clears the frame
// state and loads the configuration defaults: active level 0, 10 ticks, 60 us.
module ir_pulse_distance_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [irpd_pkg::CFG_W-1:0]    cfg_wdata,
    // pulse-pair input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [0] mark_level, [15:1] mark_ticks, [16] space_level, [31:17] space_ticks
    input  logic [31:0]                   s_tdata,
    input  logic                          s_tlast,
    // decoded frame output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] code
    output logic [31:0]                   m_tdata,
    // [2:0] status, upper bits zero
    output logic [7:0]                    m_tuser
);
    import irpd_pkg::*;

    // Configuration registers
    logic               active_level_reg;
    logic [CFG_W-1:0]   ticks_per_ten_us_reg;
    logic [CFG_W-1:0]   margin_us_reg;

    // Window bounds derived from configuration
    win_t hdr_win_reg, short_win_reg, one_win_reg, end_win_reg;

    // Input register
    logic               in_valid_reg;
    logic [31:0]        in_data_reg;
    logic               in_last_reg;

    // Frame state
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CODE_W-1:0]  shift_reg, shift_next;
    status_t            err_reg, err_next;

    // Result register
    logic               out_valid_reg;
    logic [CODE_W-1:0]  code_reg, code_next;
    status_t            status_reg, status_next;

    logic               advance;
    logic               level_ok;
    logic               mark_level, space_level;
    logic [TICKS_W-1:0] mark_ticks, space_ticks;
    logic               hdr_ok, one_ok, zero_ok, end_ok;
    logic [POS_W-1:0]   pos_inc;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg     <= 1'b0;
            ticks_per_ten_us_reg <= CFG_W'(10);
            margin_us_reg        <= CFG_W'(60);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ACTIVE_LEVEL:     active_level_reg     <= cfg_wdata[0];
                CFG_TICKS_PER_TEN_US: ticks_per_ten_us_reg <= cfg_wdata;
                CFG_MARGIN_US:        margin_us_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Bounds are registered from the configuration and follow it in the next cycle; 560 us serves three checks
    always_ff @(posedge aclk) begin
        hdr_win_reg   <= win_bounds(HDR_MARK_US, margin_us_reg, ticks_per_ten_us_reg);
        short_win_reg <= win_bounds(BIT_MARK_US, margin_us_reg, ticks_per_ten_us_reg);
        one_win_reg   <= win_bounds(ONE_SPACE_US, margin_us_reg, ticks_per_ten_us_reg);
        end_win_reg   <= win_bounds(END_SPACE_US, margin_us_reg, ticks_per_ten_us_reg);
    end

    // Handshake: a word leaves the input register unless its result cannot be stored
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Pair classification
    assign mark_level  = in_data_reg[0];
    assign mark_ticks  = in_data_reg[15:1];
    assign space_level = in_data_reg[16];
    assign space_ticks = in_data_reg[31:17];
    assign level_ok    = (mark_level == active_level_reg) && (space_level != active_level_reg);

    assign hdr_ok  = level_ok && in_win(mark_ticks, hdr_win_reg) &&
                     in_win(space_ticks, hdr_win_reg);
    assign one_ok  = level_ok && in_win(mark_ticks, short_win_reg) &&
                     in_win(space_ticks, one_win_reg);
    assign zero_ok = level_ok && in_win(mark_ticks, short_win_reg) &&
                     in_win(space_ticks, short_win_reg);
    assign end_ok  = level_ok && in_win(mark_ticks, short_win_reg) &&
                     in_win(space_ticks, end_win_reg);

    assign pos_inc = (pos_reg < POS_W'(FRAME_PAIRS)) ? pos_reg + POS_W'(1) : pos_reg;

    // Frame step and result
    always_comb begin
        shift_next  = shift_reg;
        err_next    = err_reg;
        pos_next    = pos_inc;
        status_next = err_reg;
        code_next   = '0;
        if (err_reg == ST_OK) begin
            priority if (pos_reg == '0) begin
                if (!hdr_ok) err_next = ST_HEADER;
            end else if (pos_reg <= POS_W'(FRAME_BITS)) begin
                priority if (one_ok) begin
                    shift_next = {shift_reg[CODE_W-2:0], 1'b1};
                end else if (zero_ok) begin
                    shift_next = {shift_reg[CODE_W-2:0], 1'b0};
                end else begin
                    err_next = ST_BIT;
                end
            end else if (pos_reg == POS_W'(FRAME_BITS + 1)) begin
                if (!end_ok) err_next = ST_END;
            end else begin
                err_next = err_reg;
            end
        end
        status_next = (pos_inc < POS_W'(FRAME_PAIRS)) ? ST_SHORT : err_next;
        code_next   = (status_next == ST_OK) ? shift_next : '0;
        if (in_last_reg) begin
            pos_next   = '0;
            shift_next = '0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            shift_reg <= '0;
            err_reg   <= ST_OK;
        end else if (advance) begin
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            err_reg   <= err_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            code_reg   <= code_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = code_reg;
    assign m_tuser  = {5'b0, status_reg};

`ifndef SYNTH
    // A failed frame never carries a code
    a_err_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && status_reg != ST_OK) |-> (code_reg == '0))
        else $error("non-zero code with error status");

    // Position saturates at a full frame
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(FRAME_PAIRS))
        else $error("pair position out of range");

    // Closing a frame returns the frame state to reset
    a_frame_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (pos_reg == '0 && shift_reg == '0 && err_reg == ST_OK))
        else $error("frame state not cleared on last word");

    // The first error sticks until the frame closes
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ST_OK && !(advance && in_last_reg)) |=> (err_reg == $past(err_reg)))
        else $error("first error overwritten");

    // Input stalls only when a result is waiting, not taken, behind a last word in the input register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_tready))
        else $error("input stalled without cause");
`endif

endmodule

/* sim/tb_ir_pulse_distance_decoder.sv */
// Self-checking testbench for the pulse-distance IR frame decoder, scoreboard and top module.
`timescale 1ns / 100ps

import irpd_pkg::*;

// One pulse-pair word as it goes into the decoder
typedef struct packed {
    logic        last_pair;
    logic [14:0] space_ticks;
    logic        space_level;
    logic [14:0] mark_ticks;
    logic        mark_level;
} pulse_pair_t;

// Nominal timings in microseconds
localparam int T_HDR_US   = 4500;
localparam int T_MARK_US  = 560;
localparam int T_ONE_US   = 1690;
localparam int T_ZERO_US  = 560;
localparam int T_END_US   = 0;

// Register index with no register behind it
localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

// Frame decoder model and the queue of decoded frames still to come out
class frame_scoreboard;
    typedef struct {
        logic [31:0] code;
        status_t     status;
    } frame_result_t;

    int act_level = 0;
    int ticks_k   = 10;
    int margin    = 60;

    int          pos = 0;
    logic [31:0] shift_reg = '0;
    status_t     err = ST_OK;

    frame_result_t frames_due[$];
    int checked = 0;
    int errors  = 0;

    function void set_reg(cfg_idx_t idx, int value);
        case (idx)
            CFG_ACTIVE_LEVEL:     act_level = value & 1;
            CFG_TICKS_PER_TEN_US: ticks_k = value & 1023;
            CFG_MARGIN_US:        margin = value & 1023;
            default: ;
        endcase
    endfunction

    // Window: T-M+1 <= d*10/k < T+M, kept in integers
    function bit dur_ok(logic [14:0] d, int tgt);
        int scaled;
        scaled = int'(d) * 10;
        return scaled >= (tgt - margin + 1) * ticks_k && scaled < (tgt + margin) * ticks_k;
    endfunction

    function bit pair_ok(pulse_pair_t p, int mark_us, int space_us);
        if (int'(p.mark_level) != act_level || int'(p.space_level) == act_level)
            return 1'b0;
        return dur_ok(p.mark_ticks, mark_us) && dur_ok(p.space_ticks, space_us);
    endfunction

    function void note_pair(pulse_pair_t p);
        frame_result_t r;
        // once an error is latched the rest of the frame goes unchecked
        if (err == ST_OK) begin
            if (pos == 0) begin
                if (!pair_ok(p, T_HDR_US, T_HDR_US))
                    err = ST_HEADER;
            end else if (pos <= FRAME_BITS) begin
                // a one is tried before a zero
                if (pair_ok(p, T_MARK_US, T_ONE_US))
                    shift_reg = {shift_reg[30:0], 1'b1};
                else if (pair_ok(p, T_MARK_US, T_ZERO_US))
                    shift_reg = {shift_reg[30:0], 1'b0};
                else
                    err = ST_BIT;
            end else if (pos == FRAME_BITS + 1) begin
                if (!pair_ok(p, T_MARK_US, T_END_US))
                    err = ST_END;
            end
        end
        if (pos < FRAME_PAIRS)
            pos++;
        if (p.last_pair) begin
            // too few pairs wins over any latched error
            r.status = (pos < FRAME_PAIRS) ? ST_SHORT : err;
            r.code   = (r.status == ST_OK) ? shift_reg : 32'h0;
            frames_due.push_back(r);
            pos = 0;
            shift_reg = '0;
            err = ST_OK;
        end
    endfunction

    function void check_frame(logic [31:0] code, logic [7:0] user);
        frame_result_t r;
        if (frames_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected frame, expected none, got code %h status %0d",
                     $time, code, user);
            return;
        end
        r = frames_due.pop_front();
        checked++;
        if (code !== r.code) begin
            errors++;
            $display("%0t: code mismatch, expected %h, got %h", $time, r.code, code);
        end
        if (user !== 8'(r.status)) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d", $time, r.status, user);
        end
    endfunction

    function int pending();
        return frames_due.size();
    endfunction
endclass

module tb_ir_pulse_distance_decoder;

    typedef enum {FR_CLEAN, FR_TRAILING, FR_DAMAGED, FR_TRUNCATED, FR_NOISE} frame_kind_t;

    localparam int LIMIT_NS = 2_000_000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic [7:0]           m_tuser;

    frame_scoreboard sb;

    // settings the stimulus aims at
    int cur_act    = 0;
    int cur_k      = 10;
    int cur_margin = 60;

    int words_sent  = 0;
    int frames_sent = 0;
    int settings    = 1;
    int burst_left  = 0;
    int rx_cycle    = 0;

    ir_pulse_distance_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Receiver: check accepted frames, cycling through four stall patterns
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_frame(m_tdata, m_tuser);
        rx_cycle++;
        case ((rx_cycle / 256) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_cycle % 7 == 0);
            default: m_tready <= (rx_cycle % 16 < 11);
        endcase
    end

    // Duration somewhere in the current window, now and then right on its edge
    function automatic logic [14:0] ticks_near(input int tgt);
        int lo, hi, dlo, dhi;
        lo = (tgt - cur_margin + 1) * cur_k;
        hi = (tgt + cur_margin) * cur_k;
        if (hi <= 0)
            return 15'($urandom_range(0, 32767));
        dlo = (lo <= 0) ? 0 : (lo + 9) / 10;
        dhi = (hi - 1) / 10;
        if (dhi > 32767)
            dhi = 32767;
        if (dlo > dhi)
            return 15'($urandom_range(0, 32767));
        case ($urandom_range(0, 15))
            0:       return 15'(dlo);
            1:       return 15'(dhi);
            default: return 15'($urandom_range(dhi, dlo));
        endcase
    endfunction

    function automatic pulse_pair_t make_pair(input int mark_us, input int space_us);
        pulse_pair_t p;
        p.mark_level  = 1'(cur_act);
        p.space_level = ~1'(cur_act);
        p.mark_ticks  = ticks_near(mark_us);
        p.space_ticks = ticks_near(space_us);
        p.last_pair   = 1'b0;
        return p;
    endfunction

    function automatic pulse_pair_t noise_pair();
        pulse_pair_t p;
        p = pulse_pair_t'({1'($urandom), $urandom});
        p.last_pair = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    function automatic pulse_pair_t corrupt(input pulse_pair_t p);
        pulse_pair_t q;
        q = p;
        case ($urandom_range(0, 3))
            0:       q.mark_level = ~p.mark_level;
            1:       q.space_level = ~p.space_level;
            2:       q.mark_ticks = 15'($urandom_range(0, 32767));
            default: q.space_ticks = 15'($urandom_range(0, 32767));
        endcase
        return q;
    endfunction

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)       return FR_CLEAN;
        else if (r < 10) return FR_TRAILING;
        else if (r < 15) return FR_DAMAGED;
        else if (r < 18) return FR_TRUNCATED;
        else             return FR_NOISE;
    endfunction

    // Sender: bursts of words with random gaps; valid stays up inside a burst
    task automatic send_pair(input pulse_pair_t p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {p.space_ticks, p.space_level, p.mark_ticks, p.mark_level};
        s_tlast  <= p.last_pair;
        do @(posedge aclk); while (!s_tready);
        sb.note_pair(p);
        words_sent++;
    endtask

    // Sender stops until every expected frame is out
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic send_frame(input frame_kind_t kind);
        pulse_pair_t fr[$];
        int n;
        int idx;
        fr.push_back(make_pair(T_HDR_US, T_HDR_US));
        for (int i = 0; i < FRAME_BITS; i++)
            fr.push_back(make_pair(T_MARK_US, $urandom_range(0, 1) ? T_ONE_US : T_ZERO_US));
        fr.push_back(make_pair(T_MARK_US, T_END_US));
        case (kind)
            FR_TRAILING: begin
                // pairs after the end marker are ignored
                repeat ($urandom_range(1, 4)) fr.push_back(noise_pair());
            end
            FR_DAMAGED: begin
                repeat ($urandom_range(1, 2)) begin
                    idx = $urandom_range(0, fr.size() - 1);
                    fr[idx] = corrupt(fr[idx]);
                end
            end
            FR_TRUNCATED: begin
                n = $urandom_range(1, FRAME_PAIRS - 1);
                fr = fr[0:n-1];
            end
            FR_NOISE: begin
                fr.delete();
                repeat ($urandom_range(1, 40)) fr.push_back(noise_pair());
            end
            default: ;
        endcase
        fr[fr.size() - 1].last_pair = 1'b1;
        foreach (fr[i])
            send_pair(fr[i]);
        frames_sent++;
    endtask

    // Register writes on idle decoder, one per cycle, enable lowered once
    task automatic apply_settings(input int act, input int k, input int m, input bit poke_unused);
        hold_until_drained();
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_LEVEL;
        cfg_wdata <= CFG_W'(act);
        @(posedge aclk);
        cfg_index <= CFG_TICKS_PER_TEN_US;
        cfg_wdata <= CFG_W'(k);
        @(posedge aclk);
        cfg_index <= CFG_MARGIN_US;
        cfg_wdata <= CFG_W'(m);
        @(posedge aclk);
        if (poke_unused) begin
            cfg_index <= CFG_IDX_UNUSED;
            cfg_wdata <= CFG_W'($urandom);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        sb.set_reg(CFG_ACTIVE_LEVEL, act);
        sb.set_reg(CFG_TICKS_PER_TEN_US, k);
        sb.set_reg(CFG_MARGIN_US, m);
        cur_act    = act;
        cur_k      = k;
        cur_margin = m;
        settings++;
    endtask

    task automatic run_frames(input int count);
        repeat (count) begin
            if ($urandom_range(0, 5) == 0)
                hold_until_drained();
            send_frame(pick_kind());
        end
    endtask

    // Main sequence
    initial begin
        pulse_pair_t p;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes as one-word frames, all too short
        send_pair(pulse_pair_t'({1'b1, 15'h0000, 1'b0, 15'h0000, 1'b0}));
        send_pair(pulse_pair_t'({1'b1, 15'h7fff, 1'b1, 15'h7fff, 1'b1}));
        send_pair(pulse_pair_t'({1'b1, 15'h7fff, 1'b0, 15'h0000, 1'b1}));
        // good header then a one and a zero, still too short
        send_pair(make_pair(T_HDR_US, T_HDR_US));
        send_pair(make_pair(T_MARK_US, T_ONE_US));
        p = make_pair(T_MARK_US, T_ZERO_US);
        p.last_pair = 1'b1;
        send_pair(p);
        // header with the wrong mark level, closed on its own
        p = make_pair(T_HDR_US, T_HDR_US);
        p.mark_level  = ~p.mark_level;
        p.last_pair   = 1'b1;
        send_pair(p);
        run_frames(4);

        // fixed settings at the extremes
        apply_settings(1, 10, 60, 1'b1);
        run_frames(3);
        apply_settings(0, 1, 0, 1'b0);      // empty window, nothing passes
        run_frames(2);
        apply_settings(1, 73, 1000, 1'b0);  // wide windows overlap, one wins
        run_frames(3);
        apply_settings(0, 800, 1000, 1'b0); // header out of tick range
        run_frames(2);
        apply_settings(1, 0, 60, 1'b0);     // zero tick rate: header error
        run_frames(2);
        apply_settings(0, 1, 1, 1'b0);
        run_frames(2);

        // random settings, mostly ones where frames can decode
        while (words_sent < 1100) begin
            apply_settings($urandom_range(0, 1),
                           ($urandom_range(0, 7) == 0) ? $urandom_range(0, 800)
                                                       : $urandom_range(1, 73),
                           ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1000)
                                                       : $urandom_range(1, 200),
                           1'b0);
            run_frames(4);
        end

        hold_until_drained();
        repeat (10) @(posedge aclk);
        $display("Sent %0d pulse-pair words in %0d frames over %0d register settings.",
                 words_sent, frames_sent, settings);
        $display("Checked %0d decoded frames, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("Timeout with %0d frames outstanding.", sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/irpd_pkg.sv
rtl/ir_pulse_distance_decoder.sv
sim/tb_ir_pulse_distance_decoder.sv
